### hw/rtl/pas_pkg.sv
`timescale 1ns / 1ps
package pas_pkg;
    localparam int MaxPoints = 64;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int AreaW = 34;
    localparam logic [1:0] KindSmooth = 2'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [1:0]         kind;
    } point_t;

    // Doubled triangle area, exact; operands are 17 bit differences.
    function automatic logic [AreaW-1:0] tri_area(input point_t a, input point_t b,
                                                  input point_t c);
        logic signed [16:0] dx1, dy1, dx2, dy2;
        logic signed [34:0] s;
        dx1 = 17'(b.x) - 17'(a.x);
        dy1 = 17'(b.y) - 17'(a.y);
        dx2 = 17'(c.x) - 17'(a.x);
        dy2 = 17'(c.y) - 17'(a.y);
        s = 35'(dx1 * dy2) - 35'(dx2 * dy1);
        tri_area = s[34] ? AreaW'(-s) : AreaW'(s);
    endfunction

    // p + round((q - p) / 3), difference is at most 17 bits.
    function automatic logic signed [15:0] third_toward(input logic signed [15:0] p,
                                                       input logic signed [15:0] q);
        logic signed [16:0] d;
        logic [16:0] m;
        logic [16:0] r;
        d = 17'(q) - 17'(p);
        m = d[16] ? 17'(1 - d) : 17'(d + 1);
        r = 17'((35'(m) * 35'd43691) >> 17);
        third_toward = d[16] ? 16'(p - 16'(r)) : 16'(p + 16'(r));
    endfunction
endpackage

### hw/rtl/pas_ram.sv
`timescale 1ns / 1ps
module pas_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/polyline_area_simplifier.sv
`timescale 1ns / 1ps
// Curve simplifier. Words of one curve are taken in, one point per cycle, into a
// point memory and an area memory (64 entries each, single write and single
// registered read port). When the closing word arrives (tlast, or the 64th point)
// the block accepts nothing more until all kept points have been sent. With a
// threshold of zero or under three points the points are replayed unchanged.
// Otherwise the areas of the interior points are computed first, then each
// removal scans the interior areas at one per cycle, shifts the tail down one
// entry at a time and recomputes up to two areas. The handles of the interior
// points are then set. Output: each kept point is read, registered and held
// until taken before the next one is read.
module polyline_area_simplifier
    import pas_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, in_handle_x, in_handle_y, out_handle_x, out_handle_y, kind
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_x, res_y, res_in_x, res_in_y, res_out_x, res_out_y, res_kind
    output logic [103:0] m_tdata,
    output logic         m_tlast
);
    typedef enum logic [9:0] {
        ST_LOAD = 10'd1, ST_INIT = 10'd2, ST_AREA = 10'd4, ST_SCAN = 10'd8,
        ST_SHIFT = 10'd16, ST_FIX = 10'd32, ST_HND = 10'd64, ST_OUT = 10'd128,
        ST_WAIT = 10'd256, ST_RD = 10'd512
    } state_t;

    state_t state_reg;
    logic [AreaW-1:0] thr_reg;
    logic [CntW-1:0] n_reg;
    logic [IdxW:0] i_reg;
    logic [2:0] ph_reg;
    logic bypass_reg;
    point_t a_reg, b_reg;
    logic [AreaW-1:0] best_reg;
    logic [IdxW-1:0] idx_reg;
    logic fix_sel_reg;

    logic pwe, awe;
    logic [IdxW-1:0] pwa, pra, awa, ara;
    point_t pwd, prd;
    logic [AreaW-1:0] awd, ard;

    pas_ram #(.Width($bits(point_t)), .Depth(MaxPoints)) u_pts (
        .aclk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));
    pas_ram #(.Width(AreaW), .Depth(MaxPoints)) u_area (
        .aclk, .we(awe), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(ard));

    assign pready = 1'b1;
    assign prdata = {30'd0, thr_reg};
    assign s_tready = (state_reg == ST_LOAD);

    point_t in_pt;
    assign in_pt = point_t'({
        s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48],
        s_tdata[79:64], s_tdata[95:80], s_tdata[97:96]});

    logic [IdxW:0] n1;
    assign n1 = (IdxW+1)'(n_reg);

    // Pipelined reads: address issued at ph 0, data in ph 1. The third point
    // of a triple is taken straight from the read data at ph 3.
    always_comb begin
        pwe = 1'b0; pwa = '0; pwd = in_pt; pra = '0;
        awe = 1'b0; awa = '0; awd = '0; ara = '0;
        case (state_reg)
            ST_LOAD: begin
                pwe = s_tvalid; pwa = IdxW'(n_reg);
            end
            ST_AREA, ST_FIX: begin
                pra = IdxW'(i_reg + (IdxW+1)'(ph_reg));
                awe = (ph_reg == 3'd3); awa = IdxW'(i_reg + 1'b1);
                awd = tri_area(a_reg, b_reg, prd);
            end
            ST_SCAN: ara = IdxW'(i_reg);
            ST_SHIFT: begin
                pra = IdxW'(i_reg + 1'b1); ara = IdxW'(i_reg + 1'b1);
                pwe = ph_reg[0]; awe = ph_reg[0];
                pwa = IdxW'(i_reg); awa = IdxW'(i_reg); pwd = prd; awd = ard;
            end
            ST_HND: begin
                pra = IdxW'(i_reg + (IdxW+1)'(ph_reg));
                pwe = (ph_reg == 3'd3); pwa = IdxW'(i_reg + 1'b1);
                pwd = b_reg;
                pwd.ix = third_toward(b_reg.x, a_reg.x);
                pwd.iy = third_toward(b_reg.y, a_reg.y);
                pwd.ox = third_toward(b_reg.x, prd.x);
                pwd.oy = third_toward(b_reg.y, prd.y);
                pwd.kind = KindSmooth;
            end
            default: pra = IdxW'(i_reg);
        endcase
    end

    point_t out_reg;
    logic ovalid_reg, olast_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tlast = olast_reg;
    assign m_tdata = {6'd0, out_reg.kind, out_reg.oy, out_reg.ox, out_reg.iy,
                      out_reg.ix, out_reg.y, out_reg.x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD; thr_reg <= '0; n_reg <= '0; i_reg <= '0;
            ph_reg <= '0; ovalid_reg <= 1'b0; bypass_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 1'b0) begin
                thr_reg <= pwdata[AreaW-1:0];
            end
            case (state_reg)
                ST_LOAD: if (s_tvalid) begin
                    n_reg <= n_reg + 1'b1;
                    if (s_tlast || n_reg == CntW'(MaxPoints - 1)) begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    i_reg <= '0; ph_reg <= '0;
                    bypass_reg <= (n_reg < CntW'(3)) || (thr_reg == '0);
                    state_reg <= ((n_reg < CntW'(3)) || (thr_reg == '0)) ? ST_RD : ST_AREA;
                end
                ST_AREA, ST_FIX, ST_HND: begin
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == 3'd1) a_reg <= prd;
                    if (ph_reg == 3'd2) b_reg <= prd;
                    if (ph_reg == 3'd3) begin
                        ph_reg <= '0;
                        if (state_reg == ST_FIX) begin
                            if (!fix_sel_reg && idx_reg > IdxW'(1)) begin
                                fix_sel_reg <= 1'b1; i_reg <= (IdxW+1)'(idx_reg) - 2'd2;
                            end else begin
                                state_reg <= ST_SCAN; i_reg <= (IdxW+1)'(1);
                                best_reg <= thr_reg; idx_reg <= '0;
                            end
                        end else if (i_reg + 2'd3 >= n1) begin
                            i_reg <= state_reg == ST_AREA ? (IdxW+1)'(1) : '0;
                            best_reg <= thr_reg; idx_reg <= '0;
                            state_reg <= state_reg == ST_AREA ? ST_SCAN : ST_RD;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    ph_reg <= 3'd1;
                    if (ph_reg != 3'd0 && ard < best_reg) begin
                        best_reg <= ard; idx_reg <= IdxW'(i_reg - 1'b1);
                    end
                    if (i_reg + 1'b1 < n1) begin
                        i_reg <= i_reg + 1'b1;
                    end else if (ph_reg != 3'd0) begin
                        ph_reg <= '0;
                        if (idx_reg == '0 && !(ard < best_reg)) begin
                            i_reg <= '0; state_reg <= ST_HND;
                        end else begin
                            i_reg <= (ard < best_reg) ? (IdxW+1)'(i_reg - 1'b1)
                                                     : (IdxW+1)'(idx_reg);
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT: begin
                    ph_reg <= {2'd0, ~ph_reg[0]};
                    if (ph_reg[0]) begin
                        if (i_reg + 2'd2 >= n1) begin
                            n_reg <= n_reg - 1'b1; ph_reg <= '0; fix_sel_reg <= 1'b0;
                            if (idx_reg + 2'd2 < n_reg) begin
                                i_reg <= (IdxW+1)'(idx_reg) - 1'b1; state_reg <= ST_FIX;
                            end else if (idx_reg > IdxW'(1)) begin
                                fix_sel_reg <= 1'b1;
                                i_reg <= (IdxW+1)'(idx_reg) - 2'd2; state_reg <= ST_FIX;
                            end else begin
                                best_reg <= thr_reg; idx_reg <= '0;
                                if (n_reg == CntW'(3)) begin
                                    // Only the two end points are left, which keep
                                    // their own handles, so they go straight out.
                                    i_reg <= '0; state_reg <= ST_RD;
                                end else begin
                                    i_reg <= (IdxW+1)'(1); state_reg <= ST_SCAN;
                                end
                            end
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                ST_RD: state_reg <= ST_OUT;
                ST_OUT: begin
                    out_reg <= prd; ovalid_reg <= 1'b1;
                    olast_reg <= (i_reg + 1'b1 == n1);
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: if (m_tready) begin
                    ovalid_reg <= 1'b0;
                    if (olast_reg) begin
                        n_reg <= '0; state_reg <= ST_LOAD;
                    end else begin
                        i_reg <= i_reg + 1'b1; state_reg <= ST_RD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ovalid_reg) else $error("load while output busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !bypass_reg) else $error("scan in bypass");
endmodule
